// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

    // Default value width, and depth of the job queue between front and back
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [5:0] DIGIT_MAX = 6'd9;

    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_A     = 7'h61;
    localparam logic [6:0] ASCII_MINUS = 7'h2d;
    // Digit ten maps onto 'a'
    localparam logic [6:0] LETTER_BASE = ASCII_A - 7'd10;

    // Classification of one number, handed from front to back through the queue
    typedef struct packed {
        logic [5:0] radix;
        logic       minus;
        logic       zero;
    } t_job_ctrl;

    // Back-end status, watched at the top level
    typedef struct packed {
        logic idle;
        logic dividing;
    } t_back_stat;

    function automatic logic [6:0] f_ascii(input logic [5:0] digit);
        logic [6:0] wide;
        wide = {1'b0, digit};
        if (digit > DIGIT_MAX) begin
            return wide + LETTER_BASE;
        end
        return wide + ASCII_ZERO;
    endfunction

endpackage

// ===== rtl/itoa_ram.sv =====
module itoa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/itoa_front.sv =====
module itoa_front #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic [5:0]                    i_radix,
    input  logic                          i_full,
    output logic                          o_push,
    output itoa_pkg::t_job_ctrl           o_ctrl,
    output logic [VALUE_WIDTH-1:0]        o_mag
);
    import itoa_pkg::*;

    logic [VALUE_WIDTH-1:0] bits;
    logic [5:0]             radix;
    logic                   minus;

    assign bits = i_value;

    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix = RADIX_MAX;
        end else begin
            radix = i_radix;
        end
    end

    // Negative numbers carry a sign only in base ten
    assign minus = (radix == RADIX_DEC) && bits[VALUE_WIDTH-1];

    assign o_mag        = minus ? (~bits + 1'b1) : bits;
    assign o_ctrl.radix = radix;
    assign o_ctrl.minus = minus;
    assign o_ctrl.zero  = (bits == '0);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== rtl/itoa_fifo.sv =====
module itoa_fifo #(
    parameter int WIDTH = 72,
    parameter int DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_rd_valid,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]    r_level, n_level;
    logic             push_ok;
    logic             pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_level = r_level + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full     = (r_level == LW'(DEPTH));
    assign o_rd_valid = (r_level != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/itoa_back.sv =====
module itoa_back #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  itoa_pkg::t_job_ctrl    i_job_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_job_mag,
    output logic                   o_job_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [6:0]             o_character,
    output logic                   o_last,
    output itoa_pkg::t_back_stat   o_stat
);
    import itoa_pkg::*;

    localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_ZERO = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [5:0]             r_rem, n_rem;
    logic [5:0]             r_radix, n_radix;
    logic                   r_minus, n_minus;
    logic [BW-1:0]          r_bit, n_bit;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    logic [6:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic [6:0]             rem_sh;
    logic                   ge;
    logic [5:0]             rem_nx;
    logic [VALUE_WIDTH-1:0] quo_nx;
    logic                   last_bit;
    logic                   out_free;
    logic                   out_load;
    logic [CW-1:0]          count_dec;
    logic                   wr_en;
    logic                   rd_en;
    logic [5:0]             rd_data;

    // One restoring step of the division by the radix
    assign rem_sh   = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign ge       = rem_sh >= {1'b0, r_radix};
    assign rem_nx   = ge ? 6'(rem_sh - {1'b0, r_radix}) : rem_sh[5:0];
    assign quo_nx   = {r_quo[VALUE_WIDTH-2:0], ge};
    assign last_bit = (r_bit == BW'(VALUE_WIDTH - 1));

    assign out_free  = !r_out_valid || !i_stall;
    assign count_dec = r_count - 1'b1;

    itoa_ram #(
        .WIDTH(6),
        .DEPTH(VALUE_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(rem_nx),
        .i_rd_en  (rd_en),
        .i_rd_addr(count_dec[AW-1:0]),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_radix    = r_radix;
        n_minus    = r_minus;
        n_bit      = r_bit;
        n_count    = r_count;
        n_out_char = r_out_char;
        n_out_last = r_out_last;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        o_job_pop  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_quo     = i_job_mag;
                    n_radix   = i_job_ctrl.radix;
                    n_minus   = i_job_ctrl.minus;
                    n_rem     = '0;
                    n_bit     = '0;
                    n_count   = '0;
                    n_state   = i_job_ctrl.zero ? S_ZERO : S_DIV;
                end
            end
            S_DIV: begin
                n_quo = quo_nx;
                n_rem = rem_nx;
                n_bit = r_bit + 1'b1;
                if (last_bit) begin
                    // store the remainder as the next digit, then restart
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    n_rem   = '0;
                    n_bit   = '0;
                    if (quo_nx == '0) begin
                        n_state = r_minus ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_char = ASCII_MINUS;
                    n_out_last = 1'b0;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_count = count_dec;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_char = f_ascii(rd_data);
                    n_out_last = (r_count == '0);
                    n_state    = (r_count == '0) ? S_IDLE : S_READ;
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_char = ASCII_ZERO;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = out_load || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_count     <= '0;
            r_minus     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_count     <= n_count;
            r_minus     <= n_minus;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_character     = r_out_char;
    assign o_last          = r_out_last;
    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.dividing = (r_state == S_DIV);

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// Integer to text in a radix from 2 to 36.
// Input channel (i_valid / o_stall): one transaction carries a signed value of
// VALUE_WIDTH bits and a radix; a radix outside 2..36 is clamped into range.
// Output channel (o_valid / i_stall): one transaction per ASCII character,
// most significant digit first, o_last high on the final one. Digits above
// nine are lower-case letters, zero gives "0", and only base ten shows a '-'
// for negative values; other bases read the bits as unsigned.
// A front stage classifies each number and pushes it into a two-entry queue,
// so new numbers are taken while the back end is still busy.
// The back end divides by the radix one quotient bit per cycle and keeps the
// digits in a small RAM; each character is then read from the RAM and loaded
// into the output register, after the '-' if there is one.
// A stalled output holds its character; the back end waits and the queue
// fills, after which o_stall rises. Reset is synchronous: it empties the queue,
// drops any number in progress and clears o_valid.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic [5:0]                    i_radix,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [6:0]                    o_character,
    output logic                          o_last
);
    import itoa_pkg::*;

    localparam int JOB_WIDTH = $bits(t_job_ctrl) + VALUE_WIDTH;

    logic                   push;
    logic                   full;
    t_job_ctrl              front_ctrl;
    logic [VALUE_WIDTH-1:0] front_mag;
    logic                   job_valid;
    logic [JOB_WIDTH-1:0]   job_data;
    logic                   job_pop;
    t_job_ctrl              job_ctrl;
    logic [VALUE_WIDTH-1:0] job_mag;
    t_back_stat             back_stat;

    // Classify: clamp the radix, detect zero, take the magnitude in base ten
    itoa_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_value(i_value),
        .i_radix(i_radix),
        .i_full (full),
        .o_push (push),
        .o_ctrl (front_ctrl),
        .o_mag  (front_mag)
    );

    // Decouple acceptance from the slow conversion
    itoa_fifo #(
        .WIDTH(JOB_WIDTH),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_data    ({front_ctrl, front_mag}),
        .o_full    (full),
        .o_rd_valid(job_valid),
        .o_rd_data (job_data),
        .i_pop     (job_pop)
    );

    assign job_ctrl = job_data[JOB_WIDTH-1:VALUE_WIDTH];
    assign job_mag  = job_data[VALUE_WIDTH-1:0];

    // Divide, store digits, then play them out in reverse
    itoa_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job_ctrl (job_ctrl),
        .i_job_mag  (job_mag),
        .o_job_pop  (job_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_character(o_character),
        .o_last     (o_last),
        .o_stat     (back_stat)
    );

    // No character is loaded while a division is under way
    a_no_load_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(back_stat.dividing))
        else $error("character loaded during division");

    // A number reaching an empty queue and idle back end is picked up at once
    a_pickup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !job_valid && back_stat.idle) |-> ##2 !back_stat.idle)
        else $error("queued number not picked up");

    // The sign never closes a number's text
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_character != ASCII_MINUS))
        else $error("minus sign flagged as last character");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import itoa_pkg::*;

    localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
    // Allow for a full-width base-two number on every transaction, plus output
    // stalls and long sender gaps, several times over.
    localparam int LIMIT_CYCLES = 6_000_000;
    // Quiet period after the last character. It covers one full-width number.
    localparam int TAIL_CYCLES = 4500;
    localparam int RANDOM_NUMBERS = 118;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    // Scoreboard: spells each accepted number and holds its characters until
    // the block emits them.
    class text_board;
        t_text_char pending_text[$];
        int         mismatches = 0;

        // Clamp the radix, pick the sign, divide down to digits, then queue
        // the characters most significant first.
        function void note_number(logic [VALUE_WIDTH-1:0] value, logic [5:0] radix_in);
            logic [63:0] base;
            logic [VALUE_WIDTH-1:0] remaining;
            logic [5:0] digits[$];
            logic [5:0] d;
            t_text_char ch;
            bit minus;
            base = (radix_in < RADIX_MIN) ? 64'(RADIX_MIN) :
                   (radix_in > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(radix_in);
            if (value == '0) begin
                ch.code = ASCII_ZERO;
                ch.last = 1'b1;
                pending_text.push_back(ch);
                return;
            end
            // Only base ten is signed; the most negative value wraps onto its
            // own magnitude, which reads correctly as unsigned.
            minus = value[VALUE_WIDTH-1] && (base == 64'(RADIX_DEC));
            remaining = minus ? -value : value;
            while (remaining != '0) begin
                digits.push_back(6'(remaining % base));
                remaining = remaining / base;
            end
            if (minus) begin
                ch.code = ASCII_MINUS;
                ch.last = 1'b0;
                pending_text.push_back(ch);
            end
            for (int i = digits.size() - 1; i >= 0; i--) begin
                d = digits[i];
                ch.code = (d > DIGIT_MAX) ? ({1'b0, d} - 7'd10 + ASCII_A)
                                          : ({1'b0, d} + ASCII_ZERO);
                ch.last = (i == 0);
                pending_text.push_back(ch);
            end
        endfunction

        function void check_char(logic [6:0] code, logic last);
            t_text_char want;
            if (pending_text.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected character, expected none, actual %h ('%c') last %b",
                         $time, code, code, last);
                return;
            end
            want = pending_text.pop_front();
            if (code !== want.code) begin
                mismatches++;
                $display("%0t: character mismatch, expected %h ('%c'), actual %h ('%c')",
                         $time, want.code, want.code, code, code);
            end
            if (last !== want.last) begin
                mismatches++;
                $display("%0t: last flag mismatch, expected %b, actual %b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [VALUE_WIDTH-1:0] i_value = '0;
    logic [5:0]                    i_radix = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [6:0]                    o_character;
    logic                          o_last;

    text_board board = new;
    int        burst_left = 0;
    int        cycle_count = 0;

    integer_to_ascii_radix dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Present one number and hold it until the block takes it. Called at a
    // rising edge; the payload lands for the next edge. At the accepting edge
    // either leave valid high for the next call (burst continues) or drop it
    // and idle for a while.
    task automatic send_number(input logic [VALUE_WIDTH-1:0] v, input logic [5:0] r);
        i_valid <= 1'b1;
        i_value <= v;
        i_radix <= r;
        do @(posedge i_clk); while (o_stall);
        board.note_number(v, r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            // Most bursts end in a gap; some gaps are long enough for the
            // block to drain and fall idle part way through.
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(30, 3000)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    endtask

    // Output side: check each accepted character, then choose the next stall.
    // The stall pattern switches between none, light random, heavy random and a
    // fixed duty cycle.
    int stall_mode = 0;
    int stall_age  = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_char(o_character, o_last);
        if (stall_age % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        stall_age++;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= (stall_age % 8 < 3);
        endcase
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int         near_zero;
        logic [63:0] v;
        logic [5:0]  r;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, sign handling, width extremes, letter digits and
        // radix clamping at both ends.
        send_number('0, RADIX_DEC);
        send_number('0, RADIX_MIN);
        send_number(64'd1, RADIX_MIN);
        send_number(-64'sd1, RADIX_DEC);
        send_number(-64'sd1, RADIX_MIN);
        send_number(-64'sd1, 6'd16);
        send_number(64'h7fff_ffff_ffff_ffff, RADIX_DEC);
        send_number(64'h8000_0000_0000_0000, RADIX_DEC);
        send_number(64'h8000_0000_0000_0000, 6'd16);
        send_number(64'h7fff_ffff_ffff_ffff, RADIX_MAX);
        send_number(64'd35, RADIX_MAX);
        send_number(64'd36, RADIX_MAX);
        send_number(64'd10, 6'd16);
        send_number(64'd9, RADIX_DEC);
        send_number(-64'sd123456, RADIX_DEC);
        send_number(-64'sd5, 6'd8);
        send_number(64'd5, 6'd0);
        send_number(64'd6, 6'd1);
        send_number(64'd100, 6'd37);
        send_number(-64'sd1, 6'd63);
        send_number(64'hffff_ffff_ffff_ffff, 6'd3);
        send_number(64'd1295, RADIX_MAX);

        // Random: half zero or small magnitudes so that digit counts stay low, a
        // share of 32-bit and full-width values, radix ten often, and some
        // radices outside the legal range.
        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            case ($urandom_range(0, 9))
                0: v = '0;
                1, 2, 3, 4: begin
                    near_zero = int'($urandom_range(0, 4000)) - 2000;
                    v = 64'(near_zero);
                end
                5, 6: v = 64'(int'($urandom()));
                default: v = {$urandom(), $urandom()};
            endcase
            case ($urandom_range(0, 9))
                0: r = 6'($urandom_range(0, 63));
                1, 2: r = RADIX_DEC;
                default: r = 6'($urandom_range(2, 36));
            endcase
            send_number(v, r);
        end
        i_valid <= 1'b0;

        // Drain, then hold quiet to catch any stray character.
        while (board.pending_text.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
